// File: rtl/sr_pkg.sv
// Shared types, widths and helpers for the systematic resampler.
package sr_pkg;

  localparam int unsigned MaxParticles   = 1024;
  localparam int unsigned WeightFracBits = 24;
  localparam int unsigned SumW           = WeightFracBits + 4;
  localparam int unsigned WeightW        = 25;
  localparam int unsigned RandW          = 24;
  localparam int unsigned PoseW          = 32;
  localparam int unsigned ThetaW         = 16;
  localparam int unsigned OutIdxW        = 10;

  localparam logic [WeightW-1:0] StepReset = WeightW'(16384);

  localparam logic KindLoad = 1'b0;
  localparam logic KindDraw = 1'b1;

  typedef struct packed {
    logic signed [PoseW-1:0]  x;
    logic signed [PoseW-1:0]  y;
    logic signed [ThetaW-1:0] theta;
    logic [WeightW-1:0]       weight;
  } entry_t;

  // Saturating add of two running-sum values.
  function automatic logic [SumW-1:0] sat_add(logic [SumW-1:0] a, logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
  endfunction

endpackage

// File: rtl/sr_if.sv
// Valid/ready channel interfaces for the resampler input and result words.
interface sr_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic                               first;
  logic signed [sr_pkg::PoseW-1:0]    pose_x;
  logic signed [sr_pkg::PoseW-1:0]    pose_y;
  logic signed [sr_pkg::ThetaW-1:0]   pose_theta;
  logic [sr_pkg::WeightW-1:0]         weight;
  logic [sr_pkg::RandW-1:0]           random_start;

  modport source(output valid, kind, first, pose_x, pose_y, pose_theta, weight, random_start,
                 input ready);
  modport sink(input valid, kind, first, pose_x, pose_y, pose_theta, weight, random_start,
               output ready);
endinterface

interface sr_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sr_pkg::PoseW-1:0]    out_x;
  logic signed [sr_pkg::PoseW-1:0]    out_y;
  logic signed [sr_pkg::ThetaW-1:0]   out_theta;
  logic [sr_pkg::WeightW-1:0]         out_weight;
  logic [sr_pkg::OutIdxW-1:0]         source_index;
  logic                               store_empty;

  modport source(output valid, out_x, out_y, out_theta, out_weight, source_index, store_empty,
                 input ready);
  modport sink(input valid, out_x, out_y, out_theta, out_weight, source_index, store_empty,
               output ready);
endinterface

// File: rtl/sr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/systematic_resampler_core.sv
// Systematic (low-variance) particle resampler: particle store plus walk sequencer.
//
// Channels: in_i takes words with kind = load (append pose and weight to the
// store, first restarts at slot 0) or kind = draw (emit one resampled particle).
// out_o returns one word per draw and none per load. cfg_we_i/cfg_wdata_i set
// draw_step, the threshold increment per draw (Q1.24).
// Loads are taken directly in S_IDLE, back to back. A draw goes S_IDLE, S_WALK,
// then S_ADD and back to S_WALK for every particle the walk steps over, then
// S_FETCH; the first draw of a pass passes S_FIRST (slot 0 weight fetch) before
// S_WALK, and an empty-store draw goes S_IDLE, S_EMPTY. The walk is paced by the
// single read port of the particle memory: every step of the walk reads one
// weight and waits for it. Over a pass on N particles the walk totals at most N-1 steps.
// Reset clears the fill count, walk index, running sum and threshold and sets
// draw_step to 16384; the particle memory is not cleared, only loaded slots
// are ever read. Results sit in an output register; loads are still taken
// while it waits, and a draw holds its finished word until the receiver has
// space, accepting nothing meanwhile.
module systematic_resampler_core #(
  parameter int unsigned MAX_PARTICLES = sr_pkg::MaxParticles
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sr_pkg::WeightW-1:0]  cfg_wdata_i,
  sr_in_if.sink                       in_i,
  sr_out_if.source                    out_o
);

  localparam int unsigned IdxW = $clog2(MAX_PARTICLES);
  localparam int unsigned CntW = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned CmpW = IdxW + 2;
  localparam int unsigned SumW = sr_pkg::SumW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIRST = 6'b000010,
    S_WALK  = 6'b000100,
    S_ADD   = 6'b001000,
    S_FETCH = 6'b010000,
    S_EMPTY = 6'b100000
  } state_e;

  state_e                     state_q, state_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic [SumW-1:0]            sum_q, sum_d;
  logic [SumW-1:0]            thr_q, thr_d;
  logic [sr_pkg::WeightW-1:0] step_q;

  logic                       out_valid_q, out_valid_d;
  sr_pkg::entry_t             out_ent_q;
  logic [IdxW-1:0]            out_idx_q;
  logic                       out_empty_q;
  logic                       out_load, out_load_empty, out_free;

  logic                       ram_we, ram_re;
  logic [IdxW-1:0]            ram_waddr, ram_raddr;
  sr_pkg::entry_t             ram_wdata, ram_rdata;

  logic [CmpW-1:0]            cnt_ext, idx_ext, slot_ext;
  logic [IdxW-1:0]            slot, last_idx;
  logic                       can_step;
  logic [IdxW+sr_pkg::OutIdxW-1:0] idx_wide;

  sr_ram #(
    .WIDTH ($bits(sr_pkg::entry_t)),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cnt_ext  = CmpW'(cnt_q);
  assign idx_ext  = CmpW'(idx_q);
  assign slot     = in_i.first ? '0 : cnt_q[IdxW-1:0];
  assign slot_ext = CmpW'(slot);
  assign last_idx = IdxW'(cnt_ext - CmpW'(1));
  assign can_step = (thr_q > sum_q) && ((idx_ext + CmpW'(1)) < cnt_ext);
  assign out_free = !out_valid_q || out_o.ready;

  assign ram_wdata.x      = in_i.pose_x;
  assign ram_wdata.y      = in_i.pose_y;
  assign ram_wdata.theta  = in_i.pose_theta;
  assign ram_wdata.weight = in_i.weight;
  assign ram_waddr        = slot;

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    idx_d          = idx_q;
    sum_d          = sum_q;
    thr_d          = thr_q;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = idx_q;
    out_load       = 1'b0;
    out_load_empty = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.kind == sr_pkg::KindLoad) begin
            // a load into a full store is dropped unless first is set
            if (in_i.first || (cnt_ext < CmpW'(MAX_PARTICLES))) begin
              ram_we = 1'b1;
              cnt_d  = CntW'(slot_ext + CmpW'(1));
            end
          end else if (in_i.first) begin
            thr_d = SumW'(in_i.random_start);
            idx_d = '0;
            if (cnt_q == '0) begin
              sum_d   = '0;
              state_d = S_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_d   = S_FIRST;
            end
          end else begin
            thr_d = sr_pkg::sat_add(thr_q, SumW'(step_q));
            if (cnt_q == '0) begin
              state_d = S_EMPTY;
            end else begin
              // set may have shrunk since the last draw
              if (idx_ext >= cnt_ext) begin
                idx_d = last_idx;
              end
              state_d = S_WALK;
            end
          end
        end
      end
      S_FIRST: begin
        sum_d   = SumW'(ram_rdata.weight);
        state_d = S_WALK;
      end
      S_WALK: begin
        ram_re = 1'b1;
        if (can_step) begin
          idx_d     = idx_q + IdxW'(1);
          ram_raddr = idx_q + IdxW'(1);
          state_d   = S_ADD;
        end else begin
          ram_raddr = idx_q;
          state_d   = S_FETCH;
        end
      end
      S_ADD: begin
        sum_d   = sr_pkg::sat_add(sum_q, SumW'(ram_rdata.weight));
        state_d = S_WALK;
      end
      S_FETCH: begin
        // read data holds while waiting: no new read is issued here
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_load_empty = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      sum_q       <= '0;
      thr_q       <= '0;
      step_q      <= sr_pkg::StepReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      thr_q       <= thr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_empty_q <= out_load_empty;
      if (out_load_empty) begin
        out_ent_q <= '0;
        out_idx_q <= '0;
      end else begin
        out_ent_q <= ram_rdata;
        out_idx_q <= idx_q;
      end
    end
  end

  assign idx_wide = {{sr_pkg::OutIdxW{1'b0}}, out_idx_q};

  assign out_o.valid        = out_valid_q;
  assign out_o.out_x        = out_ent_q.x;
  assign out_o.out_y        = out_ent_q.y;
  assign out_o.out_theta    = out_ent_q.theta;
  assign out_o.out_weight   = out_ent_q.weight;
  assign out_o.source_index = idx_wide[sr_pkg::OutIdxW-1:0];
  assign out_o.store_empty  = out_empty_q;

endmodule
